### rtl/core/evp_pkg.sv
`default_nettype none
package evp_pkg;

    localparam int METRICS     = 4;
    localparam int IDX_W       = 2;
    localparam int HB_IDX      = 1;
    localparam int VAL_W       = 32;
    localparam int VAR_W       = 48;
    localparam int CNT_W       = 16;
    localparam int SCORE_W     = 24;
    localparam int IN_DATA_W   = 152;
    localparam int OUT_DATA_W  = 232;

    localparam logic [15:0] ALPHA_RST = 16'd655;
    localparam logic [15:0] RCNT_RST  = 16'd360;
    localparam logic [31:0] FLOOR_RST = 32'd16384;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_RCNT  = 2'd1;
    localparam logic [1:0] CFG_FLOOR = 2'd2;

    typedef enum logic [1:0] {
        MODE_SEED   = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_SCORE  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7,
        ST_SC_START, ST_SC_WAIT, ST_NEXT, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SD_IDLE, SD_ROOT, SD_DIV
    } t_sd_state;

endpackage
`default_nettype wire

### rtl/core/evp_mul.sv
`default_nettype none
module evp_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/core/evp_sqdiv.sv
`default_nettype none
// floor(sqrt(var)) by bit pairs, then |d|*256 / root by restoring division
module evp_sqdiv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_var,
    input  wire logic [31:0] i_ad,
    output logic             o_done,
    output logic      [39:0] o_quot
);
    evp_pkg::t_sd_state r_state, n_state;
    logic [47:0] r_rad;
    logic [26:0] r_rem;
    logic [23:0] r_root;
    logic [39:0] r_num;
    logic [24:0] r_drem;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [26:0] w_rem2, w_trial;
    logic [24:0] w_dsh;
    logic        w_last;

    assign w_rem2  = {r_rem[24:0], r_rad[47:46]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_dsh   = {r_drem[23:0], r_num[39]};

    always_comb begin
        n_state = r_state;
        w_last  = 1'b0;
        unique case (r_state)
            evp_pkg::SD_IDLE: if (i_start) n_state = evp_pkg::SD_ROOT;
            evp_pkg::SD_ROOT: if (r_cnt == 6'd23) n_state = evp_pkg::SD_DIV;
            evp_pkg::SD_DIV: begin
                if (r_cnt == 6'd39) begin
                    n_state = evp_pkg::SD_IDLE;
                    w_last  = 1'b1;
                end
            end
            default: n_state = evp_pkg::SD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evp_pkg::SD_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= w_last;
            if (r_state == evp_pkg::SD_IDLE ||
                (r_state == evp_pkg::SD_ROOT && r_cnt == 6'd23)) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            evp_pkg::SD_IDLE: begin
                r_rad  <= i_var;
                r_rem  <= '0;
                r_root <= '0;
                r_num  <= {i_ad, 8'd0};
                r_drem <= '0;
            end
            evp_pkg::SD_ROOT: begin
                r_rad <= {r_rad[45:0], 2'b00};
                if (w_rem2 >= w_trial) begin
                    r_rem  <= w_rem2 - w_trial;
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[22:0], 1'b0};
                end
            end
            evp_pkg::SD_DIV: begin
                if (w_dsh >= {1'b0, r_root}) begin
                    r_drem <= w_dsh - {1'b0, r_root};
                    r_num  <= {r_num[38:0], 1'b1};
                end else begin
                    r_drem <= w_dsh;
                    r_num  <= {r_num[38:0], 1'b0};
                end
            end
            default: r_rad <= r_rad;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule
`default_nettype wire

### rtl/core/ema_variance_profiler.sv
`default_nettype none
// Exponential moving mean / variance profiler for four link metrics.
// Input stream: one beat per command. tuser = mode (0 seed, 1 update, 2 score).
// A seed beat loads the means once; a seeded update beat with learning clear
// applies the alpha step to each metric; a score beat returns per-metric
// z-scores in Q15.8. Output stream: exactly one beat per input beat with the
// means, ready mask, every-ready bit, seeded flag and scores.
// Throughput: one command at a time; s_axis_tready is high only when idle, so
// the next beat can be taken in the cycle after the result beat is delivered.
// Processing: seed and ignored beats go straight to the result; an update runs
// 8 steps per metric on the shared 32x32 multiplier (a heartbeat metric with
// under 2 samples is skipped); a score runs 24 root steps and 40 divide steps
// per metric on the shared root/divide unit (a metric that is not ready or whose
// variance is zero or below the floor scores 0 and is skipped).
// The result waits in registers while m_axis_tready is low; no new beat is
// taken until it is delivered.
// Configuration: write enable, index (0 alpha, 1 ready_count, 2 variance_floor)
// and data; write only while idle.
// Reset (synchronous, active low) clears means, variances, counts, flags and
// restores register defaults.
module ema_variance_profiler (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // learning, rssi_value, hb_value, reconnect_value, viewer_value,
    // hb_sample_count, zero pad
    input  wire logic [151:0] i_s_axis_tdata,
    // mode
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // rssi_mean, hb_mean, reconnect_mean, viewer_mean, ready_mask, every_ready,
    // seeded_flag, rssi_score, hb_score, reconnect_score, viewer_score, zero pad
    output logic      [231:0] o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);
    evp_pkg::t_state r_state, n_state;

    logic [15:0] r_alpha, r_rcnt;
    logic [31:0] r_floor;

    logic signed [31:0] r_mean [evp_pkg::METRICS];
    logic [47:0]        r_var  [evp_pkg::METRICS];
    logic [15:0]        r_cnt  [evp_pkg::METRICS];
    logic [evp_pkg::METRICS-1:0] r_ready;
    logic               r_seeded;

    logic signed [31:0] r_x [evp_pkg::METRICS];
    logic signed [23:0] r_score [evp_pkg::METRICS];
    evp_pkg::t_mode     r_mode;
    logic [15:0]        r_hbcnt;
    logic [1:0]         r_idx;

    logic signed [32:0] r_d;
    logic [31:0]        r_ad;
    logic signed [31:0] r_mnew;
    logic [31:0]        r_sq;
    logic [79:0]        r_acc;
    logic [48:0]        r_sum;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_p;
    logic        w_sd_start, w_sd_done;
    logic [39:0] w_quot;
    logic        w_in_acc;
    logic signed [32:0] w_d;
    logic [16:0] w_b;
    logic signed [49:0] w_sp;
    logic signed [33:0] w_step;
    logic signed [34:0] w_m;
    logic [79:0] w_tsum;
    logic [63:0] w_term;
    logic [47:0] w_term48;
    logic [79:0] w_vsum;
    logic [63:0] w_vres;
    logic [47:0] w_var48;
    logic [15:0] w_cnt;
    logic        w_skip;
    logic signed [23:0] w_sc;

    evp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    evp_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sd_start),
        .i_var   (r_var[r_idx]),
        .i_ad    (r_ad),
        .o_done  (w_sd_done),
        .o_quot  (w_quot)
    );

    assign o_s_axis_tready = (r_state == evp_pkg::ST_IDLE);
    assign o_m_axis_tvalid = (r_state == evp_pkg::ST_OUT);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sd_start      = (r_state == evp_pkg::ST_SC_START);

    assign w_d  = 33'(r_x[r_idx]) - 33'(r_mean[r_idx]);
    assign w_b  = 17'h10000 - {1'b0, r_alpha};

    assign w_sp   = r_d[32] ? -$signed({2'b00, w_p[47:0]}) : $signed({2'b00, w_p[47:0]});
    assign w_step = 34'((w_sp + 50'sd32768) >>> 16);
    assign w_m    = 35'(r_mean[r_idx]) + 35'(w_step);

    assign w_tsum   = r_acc + {16'd0, w_p};
    assign w_term   = w_tsum[79:16];
    assign w_term48 = (w_term[63:48] != 16'd0) ? {48{1'b1}} : w_term[47:0];

    assign w_vsum  = r_acc + {16'd0, w_p};
    assign w_vres  = w_vsum[79:16];
    assign w_var48 = (w_vres[63:48] != 16'd0) ? {48{1'b1}} : w_vres[47:0];
    assign w_cnt   = (r_cnt[r_idx] != 16'hFFFF) ? r_cnt[r_idx] + 16'd1 : r_cnt[r_idx];

    always_comb begin
        w_skip = 1'b0;
        if (r_mode == evp_pkg::MODE_UPDATE) begin
            w_skip = (r_idx == 2'(evp_pkg::HB_IDX)) && (r_hbcnt < 16'd2);
        end else begin
            w_skip = !r_ready[r_idx] || (r_var[r_idx] < {16'd0, r_floor}) ||
                     (r_var[r_idx] == 48'd0);
        end
    end

    always_comb begin
        if (w_quot > 40'd8388607) begin
            w_sc = r_d[32] ? -24'sd8388608 : 24'sd8388607;
        end else if (r_d[32]) begin
            w_sc = -$signed(w_quot[23:0]);
        end else begin
            w_sc = $signed(w_quot[23:0]);
        end
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            evp_pkg::ST_U0: begin w_ma = r_ad;            w_mb = {16'd0, r_alpha}; end
            evp_pkg::ST_U1: begin w_ma = r_ad;            w_mb = r_ad;             end
            evp_pkg::ST_U2: begin w_ma = w_p[63:32];      w_mb = {16'd0, r_alpha}; end
            evp_pkg::ST_U3: begin w_ma = r_sq;            w_mb = {16'd0, r_alpha}; end
            evp_pkg::ST_U5: begin w_ma = {15'd0, r_sum[48:32]}; w_mb = {15'd0, w_b}; end
            evp_pkg::ST_U6: begin w_ma = r_sum[31:0];     w_mb = {15'd0, w_b};     end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            evp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser == evp_pkg::MODE_SCORE ||
                        (i_s_axis_tuser == evp_pkg::MODE_UPDATE && !i_s_axis_tdata[0] &&
                         r_seeded)) begin
                        n_state = evp_pkg::ST_PREP;
                    end else begin
                        n_state = evp_pkg::ST_OUT;
                    end
                end
            end
            evp_pkg::ST_PREP: begin
                if (w_skip) n_state = evp_pkg::ST_NEXT;
                else if (r_mode == evp_pkg::MODE_UPDATE) n_state = evp_pkg::ST_U0;
                else n_state = evp_pkg::ST_SC_START;
            end
            evp_pkg::ST_U0: n_state = evp_pkg::ST_U1;
            evp_pkg::ST_U1: n_state = evp_pkg::ST_U2;
            evp_pkg::ST_U2: n_state = evp_pkg::ST_U3;
            evp_pkg::ST_U3: n_state = evp_pkg::ST_U4;
            evp_pkg::ST_U4: n_state = evp_pkg::ST_U5;
            evp_pkg::ST_U5: n_state = evp_pkg::ST_U6;
            evp_pkg::ST_U6: n_state = evp_pkg::ST_U7;
            evp_pkg::ST_U7: n_state = evp_pkg::ST_NEXT;
            evp_pkg::ST_SC_START: n_state = evp_pkg::ST_SC_WAIT;
            evp_pkg::ST_SC_WAIT: if (w_sd_done) n_state = evp_pkg::ST_NEXT;
            evp_pkg::ST_NEXT: begin
                if (r_idx == 2'(evp_pkg::METRICS - 1)) n_state = evp_pkg::ST_OUT;
                else n_state = evp_pkg::ST_PREP;
            end
            evp_pkg::ST_OUT: if (i_m_axis_tready) n_state = evp_pkg::ST_IDLE;
            default: n_state = evp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= evp_pkg::ST_IDLE;
        end else begin
            r_state  <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= evp_pkg::ALPHA_RST;
            r_rcnt   <= evp_pkg::RCNT_RST;
            r_floor  <= evp_pkg::FLOOR_RST;
            r_ready  <= '0;
            r_seeded <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < evp_pkg::METRICS; i++) begin
                r_mean[i]  <= '0;
                r_var[i]   <= '0;
                r_cnt[i]   <= '0;
                r_score[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    evp_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[15:0];
                    evp_pkg::CFG_RCNT:  r_rcnt  <= i_cfg_data[15:0];
                    evp_pkg::CFG_FLOOR: r_floor <= i_cfg_data;
                    default: r_floor <= r_floor;
                endcase
            end
            case (r_state)
                evp_pkg::ST_IDLE: begin
                    r_idx <= '0;
                    if (w_in_acc) begin
                        for (int i = 0; i < evp_pkg::METRICS; i++) r_score[i] <= '0;
                        if (i_s_axis_tuser == evp_pkg::MODE_SEED && !r_seeded) begin
                            r_seeded <= 1'b1;
                            for (int i = 0; i < evp_pkg::METRICS; i++) begin
                                r_mean[i] <= i_s_axis_tdata[1 + 32*i +: 32];
                            end
                        end
                    end
                end
                evp_pkg::ST_U7: begin
                    r_mean[r_idx] <= r_mnew;
                    r_var[r_idx]  <= w_var48;
                    r_cnt[r_idx]  <= w_cnt;
                    if (w_cnt >= r_rcnt) r_ready[r_idx] <= 1'b1;
                end
                evp_pkg::ST_SC_WAIT: if (w_sd_done) r_score[r_idx] <= w_sc;
                evp_pkg::ST_NEXT: r_idx <= r_idx + 2'd1;
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= evp_pkg::t_mode'(i_s_axis_tuser);
            r_hbcnt <= i_s_axis_tdata[144:129];
            for (int i = 0; i < evp_pkg::METRICS; i++) begin
                r_x[i] <= i_s_axis_tdata[1 + 32*i +: 32];
            end
        end
        case (r_state)
            evp_pkg::ST_PREP: begin
                r_d  <= w_d;
                r_ad <= w_d[32] ? 32'(-w_d) : w_d[31:0];
            end
            evp_pkg::ST_U1: begin
                if (w_m > 35'sd2147483647) r_mnew <= 32'sh7FFFFFFF;
                else if (w_m < -35'sd2147483648) r_mnew <= 32'sh80000000;
                else r_mnew <= w_m[31:0];
            end
            evp_pkg::ST_U2: r_sq <= w_p[31:0];
            evp_pkg::ST_U3: r_acc <= {w_p[47:0], 32'd0};
            evp_pkg::ST_U4: begin
                r_sum <= {1'b0, r_var[r_idx]} + {1'b0, w_term48};
                r_acc <= '0;
            end
            evp_pkg::ST_U6: r_acc <= {14'd0, w_p[33:0], 32'd0};
            default: r_sq <= r_sq;
        endcase
    end

    always_comb begin
        o_m_axis_tdata = '0;
        for (int i = 0; i < evp_pkg::METRICS; i++) begin
            o_m_axis_tdata[32*i +: 32]      = r_mean[i];
            o_m_axis_tdata[134 + 24*i +: 24] = r_score[i];
        end
        o_m_axis_tdata[131:128] = r_ready;
        o_m_axis_tdata[132]     = &r_ready;
        o_m_axis_tdata[133]     = r_seeded;
    end
endmodule
`default_nettype wire

### rtl/core/evp_checker.sv
`default_nettype none
module evp_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [231:0] o_m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("input open while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input open right after accept");

    a_every_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[132] == (&o_m_axis_tdata[131:128])))
        else $error("every_ready mismatch");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");
endmodule

bind ema_variance_profiler evp_checker u_evp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
